// File: src/pstl_pkg.sv
// Shared constants, codes and types for the packet sequence loss tracker.
// No dependencies; every other file of the block imports this package.
package pstl_pkg;

   // Width of the internal statistics counters.
   localparam int COUNTER_BITS = 32;
   // Saturation value of the internal statistics counters.
   localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

   // Field widths.
   localparam int SEQ_W    = 16;
   localparam int LEN_W    = 13;
   localparam int STATUS_W = 3;
   localparam int GAP_W    = 15;
   localparam int PCT_W    = 7;
   localparam int OUT_W    = 32;
   localparam int FEC_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Loss average: unsigned Q7.16, 65536 is one percent.
   localparam int AVG_W = 23;
   // Width of 9 * avg + full loss, which stays below 2^26.
   localparam int SUM_W = 26;
   localparam logic [AVG_W-1:0] Q_FULL_LOSS = 23'd6553600;
   localparam logic [AVG_W:0]   Q_HALF      = 24'd32768;

   // Reciprocal of ten: ceil(2^30 / 10). Exact for every dividend below 2^26.
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 27;
   localparam logic [RECIP_W-1:0] RECIP_TEN = 27'd107374183;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_DECODED = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_LATE    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_CONCEAL = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_SHORT   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_REPORT  = 3'd4;

   // Request function codes.
   localparam logic FUNC_PACKET = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

   // FEC recommendation codes.
   localparam logic [FEC_W-1:0] FEC_OFF   = 2'd0;
   localparam logic [FEC_W-1:0] FEC_LIGHT = 2'd1;
   localparam logic [FEC_W-1:0] FEC_HEAVY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_FEC_LIGHT_MIN     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEC_HEAVY_ABOVE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEVERE_LOSS_ABOVE = 2'd2;

   // Command to the smoothing unit.
   typedef struct packed {
      logic             start;
      logic             with_loss;
      logic [AVG_W-1:0] operand;
   } ewma_cmd_type;

   // Answer of the smoothing unit.
   typedef struct packed {
      logic             done;
      logic [AVG_W-1:0] value;
   } ewma_rsp_type;

endpackage

// File: src/pstl_if.sv
// Handshake channel interfaces of the packet sequence loss tracker.
// Depends on pstl_pkg for the field widths.

interface pstl_req_if import pstl_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    func;
   logic signed [LEN_W-1:0] packet_len;
   logic [SEQ_W-1:0]        seq;

   modport source (output valid, output func, output packet_len, output seq, input ready);
   modport sink   (input valid, input func, input packet_len, input seq, output ready);
endinterface

interface pstl_rsp_if import pstl_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [GAP_W-1:0]    gap_frames;
   logic [PCT_W-1:0]    smoothed_loss;
   logic [OUT_W-1:0]    run_lost;
   logic [OUT_W-1:0]    late_count;
   logic [OUT_W-1:0]    received_total;
   logic [OUT_W-1:0]    lost_total;
   logic [FEC_W-1:0]    fec_level;
   logic                reduce_bitrate;

   modport source (output valid, output status, output gap_frames, output smoothed_loss,
                   output run_lost, output late_count, output received_total,
                   output lost_total, output fec_level, output reduce_bitrate,
                   input ready);
   modport sink   (input valid, input status, input gap_frames, input smoothed_loss,
                   input run_lost, input late_count, input received_total,
                   input lost_total, input fec_level, input reduce_bitrate,
                   output ready);
endinterface

interface pstl_csr_if import pstl_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: src/packet_sequence_loss_tracker_core.sv
// Top level of the packet sequence loss tracker: sequencer, statistics and result register.
// Depends on pstl_pkg, the channel interfaces in pstl_if and pstl_ewma_unit.
//
//   Channel   Direction  Transfer carries
//   req_ch    in         func, packet_len, seq
//   rsp_ch    out        status, gap_frames, smoothed_loss, counters, fec_level, reduce_bitrate
//   csr_ch    in         index, data (one threshold register per write)
//
// A report or a too-short packet goes from classification straight to the result; a late
// or concealed frame first takes one loss step through the shared smoothing unit; a
// decoded packet walks its gap there frame by frame until the gap ends or the average
// settles, then takes a receive step. The block then goes idle for the next request.
// Reset is synchronous and active high; it restores the thresholds and clears the state.
// A finished result waits in the output register; a new request is taken meanwhile and
// its result is held back until the previous transfer on rsp_ch completes.
module packet_sequence_loss_tracker_core
   import pstl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   pstl_req_if.sink   req_ch,
   pstl_rsp_if.source rsp_ch,
   pstl_csr_if.sink   csr_ch
);

   typedef enum logic [8:0] {
      S_IDLE      = 9'b000000001,
      S_CLASSIFY  = 9'b000000010,
      S_LOSS_GO   = 9'b000000100,
      S_LOSS_WAIT = 9'b000001000,
      S_GAP_CHECK = 9'b000010000,
      S_GAP_WAIT  = 9'b000100000,
      S_RECV_GO   = 9'b001000000,
      S_RECV_WAIT = 9'b010000000,
      S_FINISH    = 9'b100000000
   } state_type;

   // Saturating add of a counter and a small increment.
   function automatic logic [COUNTER_BITS-1:0] sat_add(logic [COUNTER_BITS-1:0] a,
                                                        logic [SEQ_W-1:0] b);
      logic [64:0] w;
      w = 65'(a) + 65'(b);
      if (w > 65'(CNT_MAX)) begin
         return CNT_MAX;
      end
      return COUNTER_BITS'(w);
   endfunction

   // Clamp a counter to the 32-bit output field.
   function automatic logic [OUT_W-1:0] out32(logic [COUNTER_BITS-1:0] v);
      logic [63:0] w;
      w = 64'(v);
      if (w > 64'hFFFF_FFFF) begin
         return '1;
      end
      return w[OUT_W-1:0];
   endfunction

   state_type               state_ff, state_in;

   // Threshold registers.
   logic [CSR_DATA_W-1:0]   light_min_ff, heavy_above_ff, severe_above_ff;

   // Latched request.
   logic                    func_ff;
   logic signed [LEN_W-1:0] len_ff;
   logic [SEQ_W-1:0]        seq_ff;

   // Tracker state.
   logic [SEQ_W-1:0]        expected_ff, expected_in;
   logic                    awaiting_ff, awaiting_in;
   logic [AVG_W-1:0]        avg_ff, avg_in;
   logic [COUNTER_BITS-1:0] run_ff, run_in;
   logic [COUNTER_BITS-1:0] late_ff, late_in;
   logic [COUNTER_BITS-1:0] recv_ff, recv_in;
   logic [COUNTER_BITS-1:0] lost_ff, lost_in;

   // Per-item working registers.
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SEQ_W-1:0]        gap_ff, gap_in;
   logic [SEQ_W-1:0]        iter_ff, iter_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [GAP_W-1:0]        rsp_gap_ff;
   logic [PCT_W-1:0]        rsp_pct_ff;
   logic [OUT_W-1:0]        rsp_run_ff, rsp_late_ff, rsp_recv_ff, rsp_lost_ff;
   logic [FEC_W-1:0]        rsp_fec_ff;
   logic                    rsp_reduce_ff;

   ewma_cmd_type            ewma_cmd;
   ewma_rsp_type            ewma_rsp;

   logic                    req_fire, rsp_free, load_rsp;
   logic [SEQ_W-1:0]        cur_expected, behind, gap_calc;
   logic [AVG_W:0]          rounded;
   logic [PCT_W:0]          pct_wide;
   logic [PCT_W-1:0]        pct;
   logic [FEC_W-1:0]        fec;
   logic [GAP_W-1:0]        gap_shown;

   pstl_ewma_unit u_ewma (
      .clock (clock),
      .reset (reset),
      .cmd   (ewma_cmd),
      .rsp   (ewma_rsp)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // The output register is free when empty or when its transfer completes now.
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign load_rsp = (state_ff == S_FINISH) && rsp_free;

   // Before the first real packet its own number becomes the expected number.
   assign cur_expected = awaiting_ff ? seq_ff : expected_ff;
   assign behind       = cur_expected - seq_ff;
   assign gap_calc     = seq_ff - cur_expected;

   // Rounded loss percentage and the recommendations derived from it.
   always_comb begin
      rounded  = (AVG_W+1)'(avg_ff) + Q_HALF;
      pct_wide = rounded[AVG_W -: (PCT_W+1)];
      pct      = (pct_wide > (PCT_W+1)'(100)) ? PCT_W'(100) : pct_wide[PCT_W-1:0];
      if (pct > heavy_above_ff) begin
         fec = FEC_HEAVY;
      end else if (pct >= light_min_ff) begin
         fec = FEC_LIGHT;
      end else begin
         fec = FEC_OFF;
      end
      gap_shown = (gap_ff > SEQ_W'(32767)) ? GAP_W'(32767) : gap_ff[GAP_W-1:0];
   end

   // Sequencer and statistics update.
   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      awaiting_in  = awaiting_ff;
      avg_in       = avg_ff;
      run_in       = run_ff;
      late_in      = late_ff;
      recv_in      = recv_ff;
      lost_in      = lost_ff;
      status_in    = status_ff;
      gap_in       = gap_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;

      ewma_cmd.start     = 1'b0;
      ewma_cmd.with_loss = 1'b1;
      ewma_cmd.operand   = avg_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            gap_in  = '0;
            iter_in = '0;
            if (func_ff == FUNC_REPORT) begin
               status_in = STATUS_REPORT;
               state_in  = S_FINISH;
            end else if (len_ff < 0) begin
               // Late discard: one frame concealed and counted as out of order.
               status_in   = STATUS_LATE;
               late_in     = sat_add(late_ff, SEQ_W'(1));
               lost_in     = sat_add(lost_ff, SEQ_W'(1));
               run_in      = sat_add(run_ff, SEQ_W'(1));
               expected_in = expected_ff + SEQ_W'(1);
               state_in    = S_LOSS_GO;
            end else if (len_ff == '0) begin
               status_in   = STATUS_CONCEAL;
               lost_in     = sat_add(lost_ff, SEQ_W'(1));
               run_in      = sat_add(run_ff, SEQ_W'(1));
               expected_in = expected_ff + SEQ_W'(1);
               state_in    = S_LOSS_GO;
            end else if (len_ff < LEN_W'(3)) begin
               status_in = STATUS_SHORT;
               state_in  = S_FINISH;
            end else begin
               awaiting_in = 1'b0;
               if ((behind != '0) && !behind[SEQ_W-1]) begin
                  // Behind the expected number by less than half the range: late.
                  status_in   = STATUS_LATE;
                  late_in     = sat_add(late_ff, SEQ_W'(1));
                  lost_in     = sat_add(lost_ff, SEQ_W'(1));
                  run_in      = sat_add(run_ff, SEQ_W'(1));
                  expected_in = cur_expected + SEQ_W'(1);
                  state_in    = S_LOSS_GO;
               end else begin
                  // In order or ahead: the gap frames are lost, this one is received.
                  status_in   = STATUS_DECODED;
                  gap_in      = gap_calc;
                  lost_in     = sat_add(lost_ff, gap_calc);
                  run_in      = '0;
                  recv_in     = sat_add(recv_ff, SEQ_W'(1));
                  expected_in = seq_ff + SEQ_W'(1);
                  state_in    = S_GAP_CHECK;
               end
            end
         end
         S_LOSS_GO: begin
            ewma_cmd.start = 1'b1;
            state_in       = S_LOSS_WAIT;
         end
         S_LOSS_WAIT: begin
            if (ewma_rsp.done) begin
               avg_in   = ewma_rsp.value;
               state_in = S_FINISH;
            end
         end
         S_GAP_CHECK: begin
            if (iter_ff == gap_ff) begin
               state_in = S_RECV_GO;
            end else begin
               ewma_cmd.start = 1'b1;
               state_in       = S_GAP_WAIT;
            end
         end
         S_GAP_WAIT: begin
            if (ewma_rsp.done) begin
               // Once a lost frame no longer moves the average the walk is over.
               if (ewma_rsp.value == avg_ff) begin
                  state_in = S_RECV_GO;
               end else begin
                  avg_in   = ewma_rsp.value;
                  iter_in  = iter_ff + SEQ_W'(1);
                  state_in = S_GAP_CHECK;
               end
            end
         end
         S_RECV_GO: begin
            ewma_cmd.start     = 1'b1;
            ewma_cmd.with_loss = 1'b0;
            state_in           = S_RECV_WAIT;
         end
         S_RECV_WAIT: begin
            ewma_cmd.with_loss = 1'b0;
            if (ewma_rsp.done) begin
               avg_in   = ewma_rsp.value;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               // A report shows the out-of-order count and then clears it.
               if (status_ff == STATUS_REPORT) begin
                  late_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         light_min_ff    <= CSR_DATA_W'(1);
         heavy_above_ff  <= CSR_DATA_W'(5);
         severe_above_ff <= CSR_DATA_W'(15);
         expected_ff     <= '0;
         awaiting_ff     <= 1'b1;
         avg_ff          <= '0;
         run_ff          <= '0;
         late_ff         <= '0;
         recv_ff         <= '0;
         lost_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         awaiting_ff  <= awaiting_in;
         avg_ff       <= avg_in;
         run_ff       <= run_in;
         late_ff      <= late_in;
         recv_ff      <= recv_in;
         lost_ff      <= lost_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_FEC_LIGHT_MIN:     light_min_ff    <= csr_ch.data;
               REG_FEC_HEAVY_ABOVE:   heavy_above_ff  <= csr_ch.data;
               REG_SEVERE_LOSS_ABOVE: severe_above_ff <= csr_ch.data;
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      gap_ff    <= gap_in;
      iter_ff   <= iter_in;
      if (req_fire) begin
         func_ff <= req_ch.func;
         len_ff  <= req_ch.packet_len;
         seq_ff  <= req_ch.seq;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_gap_ff    <= (status_ff == STATUS_DECODED) ? gap_shown : '0;
         rsp_pct_ff    <= pct;
         rsp_run_ff    <= out32(run_ff);
         rsp_late_ff   <= out32(late_ff);
         rsp_recv_ff   <= out32(recv_ff);
         rsp_lost_ff   <= out32(lost_ff);
         rsp_fec_ff    <= fec;
         rsp_reduce_ff <= (pct > severe_above_ff);
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.gap_frames     = rsp_gap_ff;
   assign rsp_ch.smoothed_loss  = rsp_pct_ff;
   assign rsp_ch.run_lost       = rsp_run_ff;
   assign rsp_ch.late_count     = rsp_late_ff;
   assign rsp_ch.received_total = rsp_recv_ff;
   assign rsp_ch.lost_total     = rsp_lost_ff;
   assign rsp_ch.fec_level      = rsp_fec_ff;
   assign rsp_ch.reduce_bitrate = rsp_reduce_ff;

endmodule

// File: src/pstl_ewma_unit.sv
// Shared smoothing unit: computes floor((9 * a + c) / 10), c zero or full loss.
// Depends on pstl_pkg.
module pstl_ewma_unit
   import pstl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ewma_cmd_type cmd,
   output ewma_rsp_type rsp
);

   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      busy_ff, busy_in;
   logic [AVG_W-1:0]          quot_ff, quot_in;
   logic                      done_ff, done_in;
   logic [SUM_W+RECIP_W-1:0]  product;

   // First step, registered in sum_ff: scale by nine and add the loss term.
   always_comb begin
      sum_in = SUM_W'({cmd.operand, 3'b000}) + SUM_W'(cmd.operand);
      if (cmd.with_loss) begin
         sum_in = sum_in + SUM_W'(Q_FULL_LOSS);
      end
      busy_in = cmd.start;
   end

   // Second step, registered in quot_ff: divide by ten through the reciprocal.
   assign product = (SUM_W+RECIP_W)'(sum_ff) * (SUM_W+RECIP_W)'(RECIP_TEN);
   assign quot_in = product[RECIP_SHIFT +: AVG_W];
   assign done_in = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      if (cmd.start) begin
         sum_ff <= sum_in;
      end
      if (busy_ff) begin
         quot_ff <= quot_in;
      end
   end

   assign rsp.done  = done_ff;
   assign rsp.value = quot_ff;

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for packet_sequence_loss_tracker_core: sequence tracking, loss
// smoothing, counters and FEC/bitrate advice. It checks every result against its own model.
// Depends on pstl_pkg, the channel interfaces in pstl_if and the core RTL.
module tb_top
   import pstl_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // Index with no register behind it; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   // The slowest request walks about 150 gap frames, so DRAIN_CYCLES of quiet after the
   // last expected result is enough to catch a stray one.
   localparam int DRAIN_CYCLES   = 600;
   localparam int LONG_HOLD      = 400;
   localparam int PHASES         = 6;
   localparam int ITEMS_PER_PHASE = 205;
   localparam int REPORT_LIMIT   = 40;

   // One result transfer, field for field.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [GAP_W-1:0]    gap_frames;
      logic [PCT_W-1:0]    smoothed_loss;
      logic [OUT_W-1:0]    run_lost;
      logic [OUT_W-1:0]    late_count;
      logic [OUT_W-1:0]    received_total;
      logic [OUT_W-1:0]    lost_total;
      logic [FEC_W-1:0]    fec_level;
      logic                reduce_bitrate;
   } stats_word_type;

   // Hand-written status and gap for a directed request. When pinned is set these
   // values replace the model's, so the obvious cases are checked independently.
   typedef struct packed {
      logic                pinned;
      logic [STATUS_W-1:0] status;
      logic [GAP_W-1:0]    gap;
   } note_type;

   typedef struct packed {
      logic                    func;
      logic signed [LEN_W-1:0] len;
      logic [SEQ_W-1:0]        seq;
      note_type                note;
   } plan_row_type;

   logic clock;
   logic reset;

   pstl_req_if req_ch ();
   pstl_rsp_if rsp_ch ();
   pstl_csr_if csr_ch ();

   packet_sequence_loss_tracker_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Directed plan, run right after reset with the reset thresholds (1, 5, 15).
   // It walks concealment before the first packet, the first packet itself, a duplicate,
   // the late edge at distance 32767, the half-range gap of exactly 32768 frames, the
   // wrap of the sequence space and back-to-back reports.
   localparam int PLAN_ROWS = 21;
   plan_row_type directed_plan [PLAN_ROWS] = '{
      // Report straight out of reset: every statistic is zero.
      '{FUNC_REPORT, 13'sd0,     16'd0,     '{1'b1, STATUS_REPORT,  15'd0}},
      // Too short at both lengths: no state change.
      '{FUNC_PACKET, 13'sd1,     16'd0,     '{1'b1, STATUS_SHORT,   15'd0}},
      '{FUNC_PACKET, 13'sd2,     16'd65535, '{1'b1, STATUS_SHORT,   15'd0}},
      // Concealment before any packet moves the expected number from 0 upward.
      '{FUNC_PACKET, 13'sd0,     16'd77,    '{1'b1, STATUS_CONCEAL, 15'd0}},
      '{FUNC_PACKET, -13'sd1,    16'd12,    '{1'b1, STATUS_LATE,    15'd0}},
      '{FUNC_PACKET, -13'sd4096, 16'd40000, '{1'b1, STATUS_LATE,    15'd0}},
      // First real packet sets the expected number, whatever came before.
      '{FUNC_PACKET, 13'sd3,     16'd1000,  '{1'b1, STATUS_DECODED, 15'd0}},
      '{FUNC_PACKET, 13'sd4095,  16'd1001,  '{1'b1, STATUS_DECODED, 15'd0}},
      // Duplicate of the last packet.
      '{FUNC_PACKET, 13'sd500,   16'd1001,  '{1'b1, STATUS_LATE,    15'd0}},
      // Two frames missing (1003 and 1004).
      '{FUNC_PACKET, 13'sd100,   16'd1005,  '{1'b1, STATUS_DECODED, 15'd2}},
      // Exactly 32767 behind: still late.
      '{FUNC_PACKET, 13'sd64,    16'd33775, '{1'b1, STATUS_LATE,    15'd0}},
      // Exactly 32768 ahead: a forward gap, and gap_frames saturates.
      '{FUNC_PACKET, 13'sd64,    16'd33775, '{1'b1, STATUS_DECODED, 15'd32767}},
      // Large forward jump up to the top of the sequence space, then the wrap to zero.
      '{FUNC_PACKET, 13'sd3,     16'd65535, '{1'b0, STATUS_DECODED, 15'd0}},
      '{FUNC_PACKET, 13'sd3,     16'd0,     '{1'b1, STATUS_DECODED, 15'd0}},
      // Two reports: the second one sees the out-of-order count cleared.
      '{FUNC_REPORT, -13'sd1,    16'd65535, '{1'b0, STATUS_REPORT,  15'd0}},
      '{FUNC_REPORT, 13'sd4095,  16'd21845, '{1'b0, STATUS_REPORT,  15'd0}},
      // Two behind across the wrap.
      '{FUNC_PACKET, 13'sd3,     16'd65535, '{1'b1, STATUS_LATE,    15'd0}},
      '{FUNC_PACKET, 13'sd2,     16'd65535, '{1'b1, STATUS_SHORT,   15'd0}},
      '{FUNC_PACKET, 13'sd0,     16'd65535, '{1'b1, STATUS_CONCEAL, 15'd0}},
      '{FUNC_PACKET, -13'sd1,    16'd43690, '{1'b1, STATUS_LATE,    15'd0}},
      '{FUNC_PACKET, 13'sd4095,  16'd4,     '{1'b1, STATUS_DECODED, 15'd0}}
   };

   // ------------------------------------------------------------------------------------
   // Model state. It starts at the reset values; reset is applied only once.
   // ------------------------------------------------------------------------------------
   logic [CSR_DATA_W-1:0]   light_min    = 7'd1;
   logic [CSR_DATA_W-1:0]   heavy_above  = 7'd5;
   logic [CSR_DATA_W-1:0]   severe_above = 7'd15;
   logic [SEQ_W-1:0]        next_expected = '0;
   logic                    awaiting_first_packet = 1'b1;
   logic [AVG_W-1:0]        loss_avg_q16 = '0;
   logic [COUNTER_BITS-1:0] lost_run_len = '0;
   logic [COUNTER_BITS-1:0] late_since_report = '0;
   logic [COUNTER_BITS-1:0] received_count = '0;
   logic [COUNTER_BITS-1:0] lost_count = '0;

   // Results owed by the block, oldest first.
   stats_word_type predicted_stats [$];

   // Travels with each request like an extra payload field; read at the accepting edge.
   note_type req_note;

   int failures = 0;
   int results_checked = 0;
   int requests_sent = 0;
   int status_seen [5] = '{0, 0, 0, 0, 0};
   int hold_requests = 0;

   // Sender burst bookkeeping.
   int burst_left = 0;
   // Expected sequence number as the stimulus generator sees it.
   logic [SEQ_W-1:0] stream_pos;

   function automatic logic [COUNTER_BITS-1:0] sat_add(logic [COUNTER_BITS-1:0] a,
                                                      logic [COUNTER_BITS-1:0] b);
      logic [COUNTER_BITS:0] sum;
      sum = a + b;
      return sum[COUNTER_BITS] ? '1 : sum[COUNTER_BITS-1:0];
   endfunction

   // One lost frame pulls the average a tenth of the way toward 100 percent.
   function automatic logic [AVG_W-1:0] smooth_after_loss(logic [AVG_W-1:0] avg);
      logic [63:0] acc;
      acc = 64'(avg) * 64'd9 + 64'(Q_FULL_LOSS);
      return AVG_W'(acc / 64'd10);
   endfunction

   function automatic void count_lost_frame();
      loss_avg_q16  = smooth_after_loss(loss_avg_q16);
      lost_count    = sat_add(lost_count, COUNTER_BITS'(1));
      lost_run_len  = sat_add(lost_run_len, COUNTER_BITS'(1));
      next_expected = next_expected + 1'b1;
   endfunction

   // Applies one accepted request to the model state and returns the result it owes.
   function automatic stats_word_type track_event(logic func, logic signed [LEN_W-1:0] len,
                                                  logic [SEQ_W-1:0] seq);
      stats_word_type word;
      logic [SEQ_W-1:0] behind;
      logic [SEQ_W-1:0] gap;
      logic [AVG_W-1:0] settled;
      logic [AVG_W:0]   rounded;
      logic [7:0]       pct;
      word = '0;
      if (func == FUNC_REPORT) begin
         word.status = STATUS_REPORT;
      end else if (len < 0) begin
         late_since_report = sat_add(late_since_report, COUNTER_BITS'(1));
         count_lost_frame();
         word.status = STATUS_LATE;
      end else if (len == 0) begin
         count_lost_frame();
         word.status = STATUS_CONCEAL;
      end else if (len < 3) begin
         word.status = STATUS_SHORT;
      end else begin
         if (awaiting_first_packet) begin
            next_expected = seq;
            awaiting_first_packet = 1'b0;
         end
         behind = next_expected - seq;
         if (behind != 0 && behind < 16'd32768) begin
            late_since_report = sat_add(late_since_report, COUNTER_BITS'(1));
            count_lost_frame();
            word.status = STATUS_LATE;
         end else begin
            gap = seq - next_expected;
            lost_count = sat_add(lost_count, COUNTER_BITS'(gap));
            // The gap walk stops as soon as the average no longer moves.
            for (int unsigned walk = 0; walk < gap; walk++) begin
               settled = smooth_after_loss(loss_avg_q16);
               if (settled == loss_avg_q16) break;
               loss_avg_q16 = settled;
            end
            lost_run_len   = '0;
            received_count = sat_add(received_count, COUNTER_BITS'(1));
            next_expected  = seq + 1'b1;
            loss_avg_q16   = AVG_W'((64'(loss_avg_q16) * 64'd9) / 64'd10);
            word.gap_frames = (gap > 16'd32767) ? 15'd32767 : gap[GAP_W-1:0];
            word.status = STATUS_DECODED;
         end
      end

      word.late_count = late_since_report;
      if (word.status == STATUS_REPORT) late_since_report = '0;

      rounded = {1'b0, loss_avg_q16} + Q_HALF;
      pct = rounded[AVG_W:16];
      if (pct > 8'd100) pct = 8'd100;
      word.smoothed_loss = pct[PCT_W-1:0];
      if (word.smoothed_loss > heavy_above)      word.fec_level = FEC_HEAVY;
      else if (word.smoothed_loss >= light_min)  word.fec_level = FEC_LIGHT;
      else                                       word.fec_level = FEC_OFF;
      word.reduce_bitrate = (word.smoothed_loss > severe_above);
      word.run_lost       = lost_run_len;
      word.received_total = received_count;
      word.lost_total     = lost_count;
      return word;
   endfunction

   function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                       logic [OUT_W-1:0] got);
      if (got !== want) begin
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   // ------------------------------------------------------------------------------------
   // Clock and the run limit.
   // ------------------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The slowest legal run (every request a full gap walk, every result held by the
   // longest receiver stall) stays under this.
   initial begin
      #20_000_000;
      $display("Timeout with %0d results still owed.", predicted_stats.size());
      $display("** packet_sequence_loss_tracker_core: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------------------
   // Observation. Inputs are driven with nonblocking assignments at the edge, so both
   // channels are read here with the values the block itself sampled on this edge.
   // A request transfer updates the model; a result transfer is compared with the
   // oldest owed result.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin : observe
      stats_word_type want;
      if (!reset) begin
         if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
            want = track_event(req_ch.func, req_ch.packet_len, req_ch.seq);
            if (req_note.pinned) begin
               want.status     = req_note.status;
               want.gap_frames = req_note.gap;
            end
            predicted_stats.push_back(want);
         end
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            results_checked++;
            if (rsp_ch.status < 5) status_seen[rsp_ch.status]++;
            if (predicted_stats.size() == 0) begin
               failures++;
               if (failures <= REPORT_LIMIT)
                  $display("%0t: result transfer with none owed, expected nothing, got status %0d",
                           $time, rsp_ch.status);
            end else begin
               want = predicted_stats.pop_front();
               check_field("status", OUT_W'(want.status), OUT_W'(rsp_ch.status));
               check_field("gap_frames", OUT_W'(want.gap_frames), OUT_W'(rsp_ch.gap_frames));
               check_field("smoothed_loss", OUT_W'(want.smoothed_loss),
                           OUT_W'(rsp_ch.smoothed_loss));
               check_field("run_lost",       want.run_lost,       rsp_ch.run_lost);
               check_field("late_count",     want.late_count,     rsp_ch.late_count);
               check_field("received_total", want.received_total, rsp_ch.received_total);
               check_field("lost_total",     want.lost_total,     rsp_ch.lost_total);
               check_field("fec_level", OUT_W'(want.fec_level), OUT_W'(rsp_ch.fec_level));
               check_field("reduce_bitrate", OUT_W'(want.reduce_bitrate),
                           OUT_W'(rsp_ch.reduce_bitrate));
            end
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Result side back-pressure. The pattern steps through four settings in turn: always
   // ready, mostly ready, ready one cycle in three, and a coin toss. A hold request from
   // the stimulus process holds ready low until its LONG_HOLD countdown runs out, so that
   // the output register fills and the block has to refuse further requests.
   // ------------------------------------------------------------------------------------
   initial begin : result_receiver
      int unsigned hold_left;
      int unsigned cycle_count;
      int          holds_served;
      hold_left    = 0;
      cycle_count  = 0;
      holds_served = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((cycle_count / 200) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready <= ((cycle_count % 3) == 0);
               default: rsp_ch.ready <= ($urandom_range(0, 1) == 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------------------
   // Request side helpers.
   // ------------------------------------------------------------------------------------

   // Offers one request and holds it until the transfer. Valid stays high into the next
   // request of the same burst; at the end of a burst the sender may go quiet for a
   // while, with junk on the payload lines.
   task automatic offer(logic func, logic signed [LEN_W-1:0] len, logic [SEQ_W-1:0] seq,
                        note_type note);
      int pause;
      req_ch.valid      <= 1'b1;
      req_ch.func       <= func;
      req_ch.packet_len <= len;
      req_ch.seq        <= seq;
      req_note          <= note;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      requests_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         pause = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (pause != 0) begin
            req_ch.valid      <= 1'b0;
            req_ch.seq        <= SEQ_W'($urandom);
            req_ch.packet_len <= LEN_W'($urandom);
            repeat (pause) @(posedge clock);
         end
      end
   endtask

   // Stops offering and waits until every owed result has been transferred.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (predicted_stats.size() != 0) @(posedge clock);
   endtask

   // Writes one threshold register while the block is idle.
   task automatic write_threshold(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      csr_ch.valid <= 1'b0;
      case (index)
         REG_FEC_LIGHT_MIN:     light_min    = value;
         REG_FEC_HEAVY_ABOVE:   heavy_above  = value;
         REG_SEVERE_LOSS_ABOVE: severe_above = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Picks the next random request. Most are in-order packets with random content;
   // loss_weight is the percent chance that one turns into a loss event (gap, conceal,
   // late discard, duplicate or other late packet). A few requests are reports, too
   // short, or jump anywhere in the sequence space. stream_pos follows the block's
   // expected number by the same rules so that the packets stay well formed.
   task automatic pick_request(int loss_weight, output logic func,
                               output logic signed [LEN_W-1:0] len,
                               output logic [SEQ_W-1:0] seq);
      int roll;
      logic [SEQ_W-1:0] behind;
      roll = $urandom_range(0, 99);
      func = FUNC_PACKET;
      len  = LEN_W'($urandom_range(3, 4095));
      seq  = stream_pos;
      if (roll < 5) begin
         func = FUNC_REPORT;
         len  = LEN_W'($urandom);
         seq  = SEQ_W'($urandom);
      end else if (roll < 8) begin
         len = LEN_W'($urandom_range(1, 2));
         seq = SEQ_W'($urandom);
      end else if ($urandom_range(0, 99) < loss_weight) begin
         case ($urandom_range(0, 4))
            0: seq = stream_pos + SEQ_W'(($urandom_range(0, 9) == 0) ? $urandom_range(5, 400)
                                                                     : $urandom_range(1, 4));
            1: begin
               len = '0;
               seq = SEQ_W'($urandom);
            end
            2: begin
               len = LEN_W'(-int'($urandom_range(1, 4096)));
               seq = SEQ_W'($urandom);
            end
            3: seq = stream_pos - SEQ_W'($urandom_range(1, 8));
            default: seq = stream_pos - SEQ_W'($urandom_range(1, 32767));
         endcase
      end else if ($urandom_range(0, 99) < 3) begin
         seq = SEQ_W'($urandom);
      end

      if (func == FUNC_PACKET) begin
         if (len <= 0) begin
            stream_pos = stream_pos + 1'b1;
         end else if (len >= 3) begin
            behind = stream_pos - seq;
            if (behind != 0 && behind < 16'd32768) stream_pos = stream_pos + 1'b1;
            else stream_pos = seq + 1'b1;
         end
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Main sequence: reset, the directed plan, then six random phases. Each phase starts
   // from an idle block, sets the thresholds and its own loss rate. The extremes 0, 100
   // and 127 are all used, as is the unmapped register index. One phase holds the
   // result side off for a long stretch while requests keep coming, and another pauses
   // the sender midway until every owed result is back.
   // ------------------------------------------------------------------------------------
   initial begin : stimulus
      logic                    func;
      logic signed [LEN_W-1:0] len;
      logic [SEQ_W-1:0]        seq;
      int                      loss_weight;
      note_type                no_note;

      no_note = '0;
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.func       = FUNC_PACKET;
      req_ch.packet_len = '0;
      req_ch.seq        = '0;
      req_note          = '0;
      csr_ch.valid      = 1'b0;
      csr_ch.index      = REG_FEC_LIGHT_MIN;
      csr_ch.data       = '0;
      stream_pos        = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      burst_left = $urandom_range(1, 24);
      for (int row = 0; row < PLAN_ROWS; row++)
         offer(directed_plan[row].func, directed_plan[row].len, directed_plan[row].seq,
               directed_plan[row].note);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_threshold(REG_FEC_LIGHT_MIN, 7'd0);
               write_threshold(REG_FEC_HEAVY_ABOVE, 7'd0);
               write_threshold(REG_SEVERE_LOSS_ABOVE, 7'd0);
               loss_weight = 3;
            end
            1: begin
               write_threshold(REG_FEC_LIGHT_MIN, 7'd100);
               write_threshold(REG_FEC_HEAVY_ABOVE, 7'd100);
               write_threshold(REG_SEVERE_LOSS_ABOVE, 7'd100);
               loss_weight = 12;
            end
            2: begin
               // Thresholds above 100 simply never trip.
               write_threshold(REG_FEC_LIGHT_MIN, 7'd127);
               write_threshold(REG_FEC_HEAVY_ABOVE, 7'd127);
               write_threshold(REG_SEVERE_LOSS_ABOVE, 7'd127);
               write_threshold(REG_UNMAPPED, CSR_DATA_W'($urandom));
               loss_weight = 65;
            end
            3: begin
               write_threshold(REG_FEC_LIGHT_MIN, 7'd1);
               write_threshold(REG_FEC_HEAVY_ABOVE, 7'd5);
               write_threshold(REG_SEVERE_LOSS_ABOVE, 7'd15);
               loss_weight = 30;
            end
            4: begin
               write_threshold(REG_FEC_LIGHT_MIN, CSR_DATA_W'($urandom_range(0, 30)));
               write_threshold(REG_FEC_HEAVY_ABOVE, CSR_DATA_W'($urandom_range(0, 30)));
               write_threshold(REG_SEVERE_LOSS_ABOVE, CSR_DATA_W'($urandom_range(0, 30)));
               loss_weight = $urandom_range(5, 40);
            end
            default: begin
               write_threshold(REG_FEC_LIGHT_MIN, CSR_DATA_W'($urandom_range(0, 127)));
               write_threshold(REG_FEC_HEAVY_ABOVE, CSR_DATA_W'($urandom_range(0, 127)));
               write_threshold(REG_SEVERE_LOSS_ABOVE, CSR_DATA_W'($urandom_range(0, 127)));
               loss_weight = $urandom_range(0, 80);
            end
         endcase

         // The block is idle, so the model's expected number is settled here.
         stream_pos = next_expected;
         for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
            if (phase == 1 && item == 40) hold_requests <= hold_requests + 1;
            if (phase == 3 && item == 120) wait_drained();
            pick_request(loss_weight, func, len, seq);
            offer(func, len, seq, no_note);
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d requests over %0d threshold settings: %0d decoded, %0d late,",
               requests_sent, PHASES + 1, status_seen[STATUS_DECODED], status_seen[STATUS_LATE]);
      $display("%0d concealed, %0d too short, %0d reports; %0d results checked, %0d mismatches.",
               status_seen[STATUS_CONCEAL], status_seen[STATUS_SHORT],
               status_seen[STATUS_REPORT], results_checked, failures);
      if (failures == 0 && predicted_stats.size() == 0) begin
         $display("** packet_sequence_loss_tracker_core: PASSED **");
      end else begin
         $display("** packet_sequence_loss_tracker_core: FAILED **");
      end
      $finish;
   end

endmodule
